// ----- design/mqft_pkg.sv -----
// ----------------------------------------------------------------------------
// MTC quarter-frame tracker package
// Shared types, codes and the piece placement function of the tracker.
// ----------------------------------------------------------------------------
package mqft_pkg;

   localparam logic KIND_PIECE  = 1'b0;
   localparam logic KIND_PRESET = 1'b1;

   localparam logic [1:0] DIR_UNKNOWN = 2'd0;
   localparam logic [1:0] DIR_FORWARD = 2'd1;
   localparam logic [1:0] DIR_REVERSE = 2'd2;

   localparam logic [2:0] PIECE_FRAMES_LO  = 3'd0;
   localparam logic [2:0] PIECE_FRAMES_HI  = 3'd1;
   localparam logic [2:0] PIECE_SECONDS_LO = 3'd2;
   localparam logic [2:0] PIECE_SECONDS_HI = 3'd3;
   localparam logic [2:0] PIECE_MINUTES_LO = 3'd4;
   localparam logic [2:0] PIECE_MINUTES_HI = 3'd5;
   localparam logic [2:0] PIECE_HOURS_LO   = 3'd6;
   localparam logic [2:0] PIECE_HOURS_HI   = 3'd7;

   typedef struct packed {
      logic       kind;
      logic [2:0] piece_type;
      logic [3:0] piece_value;
      logic [4:0] preset_frames;
      logic [5:0] preset_seconds;
      logic [5:0] preset_minutes;
      logic [4:0] preset_hours;
      logic [1:0] preset_rate;
      logic [1:0] preset_direction;
   } item_type;

   typedef struct packed {
      logic [4:0] frames;
      logic [5:0] seconds;
      logic [5:0] minutes;
      logic [4:0] hours;
      logic [1:0] rate;
   } stamp_type;

   typedef struct packed {
      logic       updated;
      logic [1:0] direction;
      stamp_type  stamp;
   } result_type;

   function automatic stamp_type put_piece(stamp_type cur, logic [2:0] num,
                                           logic [3:0] value);
      stamp_type nxt;
      nxt = cur;
      unique case (num)
         PIECE_FRAMES_LO:  nxt.frames[3:0]  = value;
         PIECE_FRAMES_HI:  nxt.frames[4]    = value[0];
         PIECE_SECONDS_LO: nxt.seconds[3:0] = value;
         PIECE_SECONDS_HI: nxt.seconds[5:4] = value[1:0];
         PIECE_MINUTES_LO: nxt.minutes[3:0] = value;
         PIECE_MINUTES_HI: nxt.minutes[5:4] = value[1:0];
         PIECE_HOURS_LO:   nxt.hours[3:0]   = value;
         PIECE_HOURS_HI: begin
            nxt.hours[4] = value[0];
            nxt.rate     = value[2:1];
         end
         default: nxt = cur;
      endcase
      return nxt;
   endfunction

endpackage

// ----- design/mqft_in_stage.sv -----
// ----------------------------------------------------------------------------
// MTC quarter-frame tracker input stage
// Registers one request transaction and holds it until the tracker takes it.
// ----------------------------------------------------------------------------
module mqft_in_stage (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  mqft_pkg::item_type req_item,
   output logic              item_valid,
   output mqft_pkg::item_type item,
   input  logic              item_take
);

   logic               valid_ff;
   logic               valid_in;
   logic               load;
   mqft_pkg::item_type item_ff;

   assign req_stall = valid_ff && !item_take;
   assign load      = req_valid && !req_stall;
   assign valid_in  = load || (valid_ff && !item_take);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= req_item;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

// ----- design/mqft_tracker.sv -----
// ----------------------------------------------------------------------------
// MTC quarter-frame tracker core logic
// Holds the tracking state, applies one item per cycle unless a held response stalls it, and registers the result.
// ----------------------------------------------------------------------------
module mqft_tracker (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 item_valid,
   input  mqft_pkg::item_type   item,
   output logic                 item_take,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output mqft_pkg::result_type rsp_result
);

   logic                 active_ff, active_in;
   logic                 forward_ff, forward_in;
   logic [2:0]           last_ff, last_in;
   logic [1:0]           sync_ff, sync_in;
   mqft_pkg::stamp_type  stamp_ff, stamp_in;
   logic                 out_valid_ff, out_valid_in;
   mqft_pkg::result_type result_ff, result_in;

   logic                 done;
   logic                 upd;
   logic [2:0]           expect_piece;
   mqft_pkg::stamp_type  cleared;

   assign item_take    = item_valid && (!out_valid_ff || !rsp_stall);
   assign out_valid_in = item_take || (out_valid_ff && rsp_stall);
   assign expect_piece = forward_ff ? (last_ff + 3'd1) : (last_ff - 3'd1);
   assign cleared      = '0;

   always_comb begin
      active_in  = active_ff;
      forward_in = forward_ff;
      last_in    = last_ff;
      sync_in    = sync_ff;
      stamp_in   = stamp_ff;
      done       = 1'b0;
      upd        = 1'b0;
      if (item.kind == mqft_pkg::KIND_PRESET) begin
         stamp_in.frames  = item.preset_frames;
         stamp_in.seconds = item.preset_seconds;
         stamp_in.minutes = item.preset_minutes;
         stamp_in.hours   = item.preset_hours;
         stamp_in.rate    = item.preset_rate;
         if (item.preset_direction == mqft_pkg::DIR_FORWARD) begin
            sync_in    = mqft_pkg::DIR_FORWARD;
            active_in  = 1'b1;
            forward_in = 1'b1;
            last_in    = mqft_pkg::PIECE_HOURS_HI;
         end else if (item.preset_direction == mqft_pkg::DIR_REVERSE) begin
            sync_in    = mqft_pkg::DIR_REVERSE;
            active_in  = 1'b1;
            forward_in = 1'b0;
            last_in    = mqft_pkg::PIECE_FRAMES_LO;
         end else begin
            sync_in    = mqft_pkg::DIR_UNKNOWN;
            active_in  = 1'b0;
            forward_in = 1'b0;
            last_in    = mqft_pkg::PIECE_FRAMES_LO;
         end
      end else if (active_ff && (item.piece_type == expect_piece)) begin
         stamp_in = mqft_pkg::put_piece(stamp_ff, item.piece_type, item.piece_value);
         last_in  = item.piece_type;
         if (forward_ff && (item.piece_type == mqft_pkg::PIECE_HOURS_HI)) begin
            upd     = 1'b1;
            done    = 1'b1;
            sync_in = mqft_pkg::DIR_FORWARD;
         end else if (!forward_ff && (item.piece_type == mqft_pkg::PIECE_FRAMES_LO)) begin
            upd     = 1'b1;
            done    = 1'b1;
            sync_in = mqft_pkg::DIR_REVERSE;
         end
      end else begin
         // Either idle or out of order; an out-of-order piece drops all state first.
         if (active_ff) begin
            upd        = (sync_ff != mqft_pkg::DIR_UNKNOWN);
            stamp_in   = cleared;
            sync_in    = mqft_pkg::DIR_UNKNOWN;
            active_in  = 1'b0;
            forward_in = 1'b0;
            last_in    = mqft_pkg::PIECE_FRAMES_LO;
         end
         if (item.piece_type == mqft_pkg::PIECE_FRAMES_LO) begin
            stamp_in   = mqft_pkg::put_piece(stamp_in, item.piece_type, item.piece_value);
            active_in  = 1'b1;
            forward_in = 1'b1;
            last_in    = mqft_pkg::PIECE_FRAMES_LO;
         end else if (item.piece_type == mqft_pkg::PIECE_HOURS_HI) begin
            stamp_in   = mqft_pkg::put_piece(stamp_in, item.piece_type, item.piece_value);
            active_in  = 1'b1;
            forward_in = 1'b0;
            last_in    = mqft_pkg::PIECE_HOURS_HI;
         end
      end
      result_in.updated   = upd;
      result_in.direction = sync_in;
      result_in.stamp     = done ? stamp_in : cleared;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         forward_ff   <= 1'b0;
         last_ff      <= mqft_pkg::PIECE_FRAMES_LO;
         sync_ff      <= mqft_pkg::DIR_UNKNOWN;
         stamp_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         if (item_take) begin
            active_ff  <= active_in;
            forward_ff <= forward_in;
            last_ff    <= last_in;
            sync_ff    <= sync_in;
            stamp_ff   <= stamp_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (item_take) begin
         result_ff <= result_in;
      end
   end

   assign rsp_valid  = out_valid_ff;
   assign rsp_result = result_ff;

   a_sync_needs_tracking: assert property (@(posedge clock) disable iff (reset)
      (sync_ff != mqft_pkg::DIR_UNKNOWN) |-> active_ff)
      else $error("Sync direction is known while the tracker is idle.");

   a_done_reports_update: assert property (@(posedge clock) disable iff (reset)
      (item_take && done) |=> (rsp_valid && result_ff.updated &&
                               (result_ff.direction != mqft_pkg::DIR_UNKNOWN)))
      else $error("A completed run did not report an update with a direction.");

   a_done_keeps_tracking: assert property (@(posedge clock) disable iff (reset)
      (item_take && done) |=> active_ff)
      else $error("The tracker stopped after a completed run.");

   a_take_fills_output: assert property (@(posedge clock) disable iff (reset)
      item_take |=> out_valid_ff)
      else $error("A taken transaction left no result.");

endmodule

// ----- design/mtc_quarter_frame_tracker_core.sv -----
// ----------------------------------------------------------------------------
// MTC quarter-frame tracker
// Reassembles MIDI time code quarter-frame pieces into a full time stamp.
// ----------------------------------------------------------------------------
// The request channel carries either a quarter-frame piece (type and four data
// bits) or a preset that loads a time and a sync direction. Every request
// transaction yields exactly one response transaction, in order.
// A response reports updated when a run of eight pieces completes or when sync
// is lost, the current sync direction, and the assembled time on completion
// (zero otherwise).
// A request is registered on acceptance and held in the input stage until the
// tracker takes it, which updates the tracking state and registers the result.
// One transaction per cycle is sustained while the receiver does not stall.
// When the receiver stalls, the response is held and the input register
// keeps one more transaction, after which req_stall is raised.
// Synchronous reset clears the tracking state, the sync direction and the
// assembled time, and empties both registers.
// ----------------------------------------------------------------------------
module mtc_quarter_frame_tracker_core (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic       req_kind,
   input  logic [2:0] req_piece_type,
   input  logic [3:0] req_piece_value,
   input  logic [4:0] req_preset_frames,
   input  logic [5:0] req_preset_seconds,
   input  logic [5:0] req_preset_minutes,
   input  logic [4:0] req_preset_hours,
   input  logic [1:0] req_preset_rate,
   input  logic [1:0] req_preset_direction,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_updated,
   output logic [1:0] rsp_direction_out,
   output logic [4:0] rsp_frames_out,
   output logic [5:0] rsp_seconds_out,
   output logic [5:0] rsp_minutes_out,
   output logic [4:0] rsp_hours_out,
   output logic [1:0] rsp_rate_out
);

   mqft_pkg::item_type   req_item;
   mqft_pkg::item_type   item;
   logic                 item_valid;
   logic                 item_take;
   mqft_pkg::result_type result;

   assign req_item.kind             = req_kind;
   assign req_item.piece_type       = req_piece_type;
   assign req_item.piece_value      = req_piece_value;
   assign req_item.preset_frames    = req_preset_frames;
   assign req_item.preset_seconds   = req_preset_seconds;
   assign req_item.preset_minutes   = req_preset_minutes;
   assign req_item.preset_hours     = req_preset_hours;
   assign req_item.preset_rate      = req_preset_rate;
   assign req_item.preset_direction = req_preset_direction;

   mqft_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_item   (req_item),
      .item_valid (item_valid),
      .item       (item),
      .item_take  (item_take)
   );

   mqft_tracker u_tracker (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .item       (item),
      .item_take  (item_take),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_result (result)
   );

   assign rsp_updated       = result.updated;
   assign rsp_direction_out = result.direction;
   assign rsp_frames_out    = result.stamp.frames;
   assign rsp_seconds_out   = result.stamp.seconds;
   assign rsp_minutes_out   = result.stamp.minutes;
   assign rsp_hours_out     = result.stamp.hours;
   assign rsp_rate_out      = result.stamp.rate;

endmodule

// ----- bench/mtc_quarter_frame_tracker_core_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// MTC quarter-frame tracker testbench
// Drives quarter-frame pieces and presets into the tracker and checks every
// response against a cycle-free model of the tracking state. The stimulus is
// a short directed part followed by random runs, broken runs, presets and
// noise. The sender and the receiver idle and stall at random.
// ----------------------------------------------------------------------------
module mtc_quarter_frame_tracker_core_tb;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int ITEM_TARGET    = 550;

   class timecode_tracker_board;
      logic                 active;
      logic                 forward;
      logic [2:0]           last_num;
      logic [1:0]           sync_dir;
      mqft_pkg::stamp_type  stamp;
      mqft_pkg::result_type pending_results[$];
      int                   mismatches;
      int                   checked;
      int                   presets;
      int                   runs_done;
      int                   sync_losses;

      function new();
         active = 1'b0;
         forward = 1'b0;
         last_num = '0;
         sync_dir = mqft_pkg::DIR_UNKNOWN;
         stamp = '0;
         mismatches = 0;
         checked = 0;
         presets = 0;
         runs_done = 0;
         sync_losses = 0;
      endfunction

      function void place(logic [2:0] num, logic [3:0] value);
         case (num)
            mqft_pkg::PIECE_FRAMES_LO:  stamp.frames[3:0]  = value;
            mqft_pkg::PIECE_FRAMES_HI:  stamp.frames[4]    = value[0];
            mqft_pkg::PIECE_SECONDS_LO: stamp.seconds[3:0] = value;
            mqft_pkg::PIECE_SECONDS_HI: stamp.seconds[5:4] = value[1:0];
            mqft_pkg::PIECE_MINUTES_LO: stamp.minutes[3:0] = value;
            mqft_pkg::PIECE_MINUTES_HI: stamp.minutes[5:4] = value[1:0];
            mqft_pkg::PIECE_HOURS_LO:   stamp.hours[3:0]   = value;
            default: begin
               stamp.hours[4] = value[0];
               stamp.rate     = value[2:1];
            end
         endcase
      endfunction

      function void start_run(logic [2:0] num, logic [3:0] value);
         if (num == mqft_pkg::PIECE_FRAMES_LO) begin
            place(num, value);
            active = 1'b1;
            forward = 1'b1;
            last_num = mqft_pkg::PIECE_FRAMES_LO;
         end else if (num == mqft_pkg::PIECE_HOURS_HI) begin
            place(num, value);
            active = 1'b1;
            forward = 1'b0;
            last_num = mqft_pkg::PIECE_HOURS_HI;
         end
      endfunction

      function void note_request(mqft_pkg::item_type it);
         mqft_pkg::result_type res;
         logic [2:0]           wanted;
         logic                 done;
         res = '0;
         done = 1'b0;
         if (it.kind == mqft_pkg::KIND_PRESET) begin
            presets++;
            stamp.frames  = it.preset_frames;
            stamp.seconds = it.preset_seconds;
            stamp.minutes = it.preset_minutes;
            stamp.hours   = it.preset_hours;
            stamp.rate    = it.preset_rate;
            if (it.preset_direction == mqft_pkg::DIR_FORWARD) begin
               sync_dir = mqft_pkg::DIR_FORWARD;
               active = 1'b1;
               forward = 1'b1;
               last_num = mqft_pkg::PIECE_HOURS_HI;
            end else if (it.preset_direction == mqft_pkg::DIR_REVERSE) begin
               sync_dir = mqft_pkg::DIR_REVERSE;
               active = 1'b1;
               forward = 1'b0;
               last_num = mqft_pkg::PIECE_FRAMES_LO;
            end else begin
               sync_dir = mqft_pkg::DIR_UNKNOWN;
               active = 1'b0;
               forward = 1'b0;
               last_num = mqft_pkg::PIECE_FRAMES_LO;
            end
         end else if (!active) begin
            start_run(it.piece_type, it.piece_value);
         end else begin
            wanted = forward ? last_num + 3'd1 : last_num - 3'd1;
            if (it.piece_type == wanted) begin
               place(it.piece_type, it.piece_value);
               last_num = it.piece_type;
               if (forward && it.piece_type == mqft_pkg::PIECE_HOURS_HI) begin
                  done = 1'b1;
                  sync_dir = mqft_pkg::DIR_FORWARD;
               end else if (!forward && it.piece_type == mqft_pkg::PIECE_FRAMES_LO) begin
                  done = 1'b1;
                  sync_dir = mqft_pkg::DIR_REVERSE;
               end
            end else begin
               if (sync_dir != mqft_pkg::DIR_UNKNOWN) begin
                  res.updated = 1'b1;
                  sync_losses++;
               end
               stamp = '0;
               sync_dir = mqft_pkg::DIR_UNKNOWN;
               active = 1'b0;
               forward = 1'b0;
               last_num = mqft_pkg::PIECE_FRAMES_LO;
               start_run(it.piece_type, it.piece_value);
            end
         end
         if (done) begin
            res.updated = 1'b1;
            res.stamp = stamp;
            runs_done++;
         end
         res.direction = sync_dir;
         pending_results.push_back(res);
      endfunction

      function void compare_field(string name, logic [5:0] want, logic [5:0] got);
         if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("Mismatch on response %0d, %s: expected %0d, got %0d",
                        checked, name, want, got);
            end
         end
      endfunction

      function void check_response(mqft_pkg::result_type got);
         mqft_pkg::result_type want;
         if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("Unexpected response with no request outstanding: %h", got);
            end
            return;
         end
         want = pending_results.pop_front();
         compare_field("updated", 6'(want.updated), 6'(got.updated));
         compare_field("direction", 6'(want.direction), 6'(got.direction));
         compare_field("frames", 6'(want.stamp.frames), 6'(got.stamp.frames));
         compare_field("seconds", want.stamp.seconds, got.stamp.seconds);
         compare_field("minutes", want.stamp.minutes, got.stamp.minutes);
         compare_field("hours", 6'(want.stamp.hours), 6'(got.stamp.hours));
         compare_field("rate", 6'(want.stamp.rate), 6'(got.stamp.rate));
         checked++;
      endfunction
   endclass

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_stall;
   logic       req_kind;
   logic [2:0] req_piece_type;
   logic [3:0] req_piece_value;
   logic [4:0] req_preset_frames;
   logic [5:0] req_preset_seconds;
   logic [5:0] req_preset_minutes;
   logic [4:0] req_preset_hours;
   logic [1:0] req_preset_rate;
   logic [1:0] req_preset_direction;
   logic       rsp_valid;
   logic       rsp_stall;
   logic       rsp_updated;
   logic [1:0] rsp_direction_out;
   logic [4:0] rsp_frames_out;
   logic [5:0] rsp_seconds_out;
   logic [5:0] rsp_minutes_out;
   logic [4:0] rsp_hours_out;
   logic [1:0] rsp_rate_out;

   timecode_tracker_board board;
   int send_gap_pct;
   int rsp_hold_pct;
   int items_sent;
   int quiet_cycles;

   mtc_quarter_frame_tracker_core dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_kind             (req_kind),
      .req_piece_type       (req_piece_type),
      .req_piece_value      (req_piece_value),
      .req_preset_frames    (req_preset_frames),
      .req_preset_seconds   (req_preset_seconds),
      .req_preset_minutes   (req_preset_minutes),
      .req_preset_hours     (req_preset_hours),
      .req_preset_rate      (req_preset_rate),
      .req_preset_direction (req_preset_direction),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_updated          (rsp_updated),
      .rsp_direction_out    (rsp_direction_out),
      .rsp_frames_out       (rsp_frames_out),
      .rsp_seconds_out      (rsp_seconds_out),
      .rsp_minutes_out      (rsp_minutes_out),
      .rsp_hours_out        (rsp_hours_out),
      .rsp_rate_out         (rsp_rate_out)
   );

   always #4 clock = ~clock;

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            board.check_response(mqft_pkg::result_type'({rsp_updated, rsp_direction_out,
               rsp_frames_out, rsp_seconds_out, rsp_minutes_out, rsp_hours_out,
               rsp_rate_out}));
         end
         rsp_stall <= ($urandom_range(99) < rsp_hold_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            quiet_cycles <= 0;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog expired after %0d cycles without a transaction.",
                     quiet_cycles);
            $display("CHECKS FAILED");
            $finish;
         end
      end
   end

   function automatic mqft_pkg::item_type random_item();
      mqft_pkg::item_type it;
      it.kind             = mqft_pkg::KIND_PIECE;
      it.piece_type       = 3'($urandom);
      it.piece_value      = 4'($urandom);
      it.preset_frames    = 5'($urandom);
      it.preset_seconds   = 6'($urandom);
      it.preset_minutes   = 6'($urandom);
      it.preset_hours     = 5'($urandom);
      it.preset_rate      = 2'($urandom);
      it.preset_direction = 2'($urandom);
      return it;
   endfunction

   task automatic send_item(input mqft_pkg::item_type it);
      while ($urandom_range(99) < send_gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid            <= 1'b1;
      req_kind             <= it.kind;
      req_piece_type       <= it.piece_type;
      req_piece_value      <= it.piece_value;
      req_preset_frames    <= it.preset_frames;
      req_preset_seconds   <= it.preset_seconds;
      req_preset_minutes   <= it.preset_minutes;
      req_preset_hours     <= it.preset_hours;
      req_preset_rate      <= it.preset_rate;
      req_preset_direction <= it.preset_direction;
      do @(posedge clock); while (req_stall);
      board.note_request(it);
      items_sent++;
      if (items_sent < ITEM_TARGET / 3) begin
         send_gap_pct = 9;
         rsp_hold_pct = 50;
      end else if (items_sent < 2 * ITEM_TARGET / 3) begin
         send_gap_pct = 50;
         rsp_hold_pct = 9;
      end else begin
         send_gap_pct = 0;
         rsp_hold_pct = 0;
      end
   endtask

   task automatic send_piece(input logic [2:0] num, input logic [3:0] value);
      mqft_pkg::item_type it;
      it = random_item();
      it.kind = mqft_pkg::KIND_PIECE;
      it.piece_type = num;
      it.piece_value = value;
      send_item(it);
   endtask

   task automatic send_preset(input logic [4:0] frames, input logic [5:0] seconds,
                              input logic [5:0] minutes, input logic [4:0] hours,
                              input logic [1:0] rate, input logic [1:0] dir);
      mqft_pkg::item_type it;
      it = random_item();
      it.kind = mqft_pkg::KIND_PRESET;
      it.preset_frames = frames;
      it.preset_seconds = seconds;
      it.preset_minutes = minutes;
      it.preset_hours = hours;
      it.preset_rate = rate;
      it.preset_direction = dir;
      send_item(it);
   endtask

   task automatic send_run(input logic fwd, input int length, input int fill);
      logic [2:0] num;
      logic [3:0] value;
      for (int i = 0; i < length; i++) begin
         num = fwd ? 3'(i) : 3'(7 - i);
         value = (fill < 0) ? 4'($urandom) : 4'(fill);
         send_piece(num, value);
      end
   endtask

   initial begin
      int pick;
      clock = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_kind = mqft_pkg::KIND_PIECE;
      req_piece_type = '0;
      req_piece_value = '0;
      req_preset_frames = '0;
      req_preset_seconds = '0;
      req_preset_minutes = '0;
      req_preset_hours = '0;
      req_preset_rate = '0;
      req_preset_direction = mqft_pkg::DIR_UNKNOWN;
      rsp_stall = 1'b0;
      quiet_cycles = 0;
      items_sent = 0;
      send_gap_pct = 9;
      rsp_hold_pct = 50;
      board = new();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      send_piece(mqft_pkg::PIECE_SECONDS_HI, 4'hF);
      send_run(1'b1, 8, 15);
      send_piece(mqft_pkg::PIECE_HOURS_HI, 4'h0);
      send_run(1'b0, 8, 0);
      send_preset(5'd31, 6'd63, 6'd63, 5'd31, 2'd3, mqft_pkg::DIR_FORWARD);
      send_piece(mqft_pkg::PIECE_FRAMES_LO, 4'h5);
      send_preset(5'd0, 6'd0, 6'd0, 5'd0, 2'd0, 2'd3);
      send_preset(5'd29, 6'd59, 6'd59, 5'd23, 2'd2, mqft_pkg::DIR_REVERSE);
      send_piece(mqft_pkg::PIECE_SECONDS_HI, 4'hA);
      send_preset(5'd1, 6'd2, 6'd3, 5'd4, 2'd1, mqft_pkg::DIR_UNKNOWN);

      while (items_sent < ITEM_TARGET) begin
         pick = $urandom_range(99);
         if (pick < 55) begin
            send_run(1'($urandom_range(1)), 8, -1);
         end else if (pick < 70) begin
            send_run(1'($urandom_range(1)), $urandom_range(1, 7), -1);
            send_piece(3'($urandom), 4'($urandom));
         end else if (pick < 80) begin
            send_preset(5'($urandom), 6'($urandom), 6'($urandom), 5'($urandom),
                        2'($urandom), 2'($urandom));
         end else begin
            send_piece(3'($urandom), 4'($urandom));
         end
      end
      req_valid <= 1'b0;

      while (board.pending_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);

      $display("Run covered %0d requests with %0d presets, %0d checked responses,",
               items_sent, board.presets, board.checked);
      $display("%0d completed runs and %0d sync losses; %0d mismatches.",
               board.runs_done, board.sync_losses, board.mismatches);
      if (board.mismatches == 0 && board.pending_results.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

// ----- files.f -----
design/mqft_pkg.sv
design/mqft_in_stage.sv
design/mqft_tracker.sv
design/mtc_quarter_frame_tracker_core.sv
bench/mtc_quarter_frame_tracker_core_tb.sv
